### design/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// shared types, flag masks and endpoint state codes for the session tracker
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam logic [7:0] FlagFin  = 8'h01;
  localparam logic [7:0] FlagSyn  = 8'h02;
  localparam logic [7:0] FlagRst  = 8'h04;
  localparam logic [7:0] FlagAck  = 8'h10;
  localparam logic [7:0] FlagMask = FlagFin | FlagSyn | FlagRst | FlagAck;

  localparam logic [3:0] StClosed      = 4'd0;
  localparam logic [3:0] StListen      = 4'd1;
  localparam logic [3:0] StSynSent     = 4'd2;
  localparam logic [3:0] StSynRcvd     = 4'd3;
  localparam logic [3:0] StEstablished = 4'd4;
  localparam logic [3:0] StFinWait1    = 4'd5;
  localparam logic [3:0] StFinWait2    = 4'd6;
  localparam logic [3:0] StTimeWait    = 4'd7;
  localparam logic [3:0] StClosing     = 4'd8;
  localparam logic [3:0] StCloseWait   = 4'd9;
  localparam logic [3:0] StLastAck     = 4'd10;

  typedef struct packed {
    logic        send;
    logic        recv;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [15:0] len;
  } ep_cmd_t;

  typedef struct packed {
    logic       seq_ok;
    logic       changed;
    logic [3:0] state_next;
  } ep_stat_t;

endpackage

### design/tst_in_stage.sv
// ----------------------------------------------------------------------------
// tst_in_stage
// input register for one segment transaction
// ----------------------------------------------------------------------------
module tst_in_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  tcp_flags_i,
  input  logic [31:0] seq_number_i,
  input  logic [15:0] payload_length_i,
  input  logic        direction_i,
  input  logic        take_i,
  output logic        valid_o,
  output logic [7:0]  flags_o,
  output logic [31:0] seq_o,
  output logic [15:0] len_o,
  output logic        dir_o
);

  logic        valid_q, valid_d;
  logic [7:0]  flags_q;
  logic [31:0] seq_q;
  logic [15:0] len_q;
  logic        dir_q;
  logic        load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q <= tcp_flags_i & tst_pkg::FlagMask;
      seq_q   <= seq_number_i;
      len_q   <= payload_length_i;
      dir_q   <= direction_i;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign seq_o   = seq_q;
  assign len_o   = len_q;
  assign dir_o   = dir_q;

endmodule

### design/tst_endpoint.sv
// ----------------------------------------------------------------------------
// tst_endpoint
// one endpoint: state machine, sequence check and length counters
// ----------------------------------------------------------------------------
module tst_endpoint (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tst_pkg::ep_cmd_t cmd_i,
  output tst_pkg::ep_stat_t stat_o
);

  logic [3:0]  state_q, state_d;
  logic [31:0] base_q, base_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] ack_q, ack_d;
  logic        seq_valid_q, seq_valid_d;
  logic        ack_valid_q, ack_valid_d;
  logic        fin_q, fin_d;
  logic        changed;
  logic [31:0] lim;
  logic [7:0]  f;

  assign f   = cmd_i.flags;
  assign lim = base_q + sent_q + 32'd1;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    sent_d      = sent_q;
    ack_d       = ack_q;
    seq_valid_d = seq_valid_q;
    ack_valid_d = ack_valid_q;
    fin_d       = fin_q;
    changed     = 1'b0;
    if (cmd_i.send) begin
      case (state_q)
        tst_pkg::StClosed: begin
          if (f == tst_pkg::FlagSyn) begin
            state_d     = tst_pkg::StSynSent;
            changed     = 1'b1;
            base_d      = cmd_i.seq;
            seq_valid_d = 1'b1;
          end
        end
        tst_pkg::StListen: begin
          if (f == (tst_pkg::FlagSyn | tst_pkg::FlagAck)) begin
            state_d     = tst_pkg::StSynRcvd;
            changed     = 1'b1;
            base_d      = cmd_i.seq;
            seq_valid_d = 1'b1;
          end
        end
        tst_pkg::StSynSent: begin
          if (f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StEstablished;
            changed = 1'b1;
          end
        end
        tst_pkg::StSynRcvd: begin
          changed = 1'b1;
          state_d = (f == tst_pkg::FlagFin) ? tst_pkg::StFinWait1 : tst_pkg::StEstablished;
        end
        tst_pkg::StEstablished: begin
          if (f == tst_pkg::FlagFin) begin
            state_d = tst_pkg::StFinWait1;
            changed = 1'b1;
          end else if (f == tst_pkg::FlagAck && fin_q) begin
            state_d = tst_pkg::StCloseWait;
            changed = 1'b1;
          end
        end
        tst_pkg::StFinWait1: begin
          if (f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StClosing;
            changed = 1'b1;
          end
        end
        tst_pkg::StFinWait2: begin
          if (fin_q && f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StTimeWait;
            changed = 1'b1;
          end
        end
        tst_pkg::StCloseWait: begin
          if (f == tst_pkg::FlagFin) begin
            state_d = tst_pkg::StLastAck;
            changed = 1'b1;
          end
        end
        tst_pkg::StLastAck: begin
          if (f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StClosed;
            changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state_d == tst_pkg::StEstablished) begin
        sent_d = sent_q + {16'd0, cmd_i.len};
      end
    end else if (cmd_i.recv) begin
      case (state_q)
        tst_pkg::StClosed: begin
          if (f == tst_pkg::FlagSyn) begin
            state_d     = tst_pkg::StListen;
            changed     = 1'b1;
            ack_d       = cmd_i.seq + 32'd1;
            ack_valid_d = 1'b1;
          end
        end
        tst_pkg::StSynSent: begin
          if (f == (tst_pkg::FlagSyn | tst_pkg::FlagAck)) begin
            ack_d       = cmd_i.seq + 32'd1;
            ack_valid_d = 1'b1;
          end
        end
        tst_pkg::StEstablished, tst_pkg::StFinWait2: begin
          if (f == tst_pkg::FlagFin) begin
            fin_d = 1'b1;
          end
        end
        tst_pkg::StFinWait1: begin
          if (f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StFinWait2;
            changed = 1'b1;
          end
        end
        tst_pkg::StClosing: begin
          if (f == tst_pkg::FlagAck) begin
            state_d = tst_pkg::StTimeWait;
            changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state_d == tst_pkg::StEstablished || state_d == tst_pkg::StSynRcvd) begin
        ack_d = ack_q + {16'd0, cmd_i.len};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tst_pkg::StClosed;
      base_q      <= 32'd0;
      sent_q      <= 32'd0;
      ack_q       <= 32'd0;
      seq_valid_q <= 1'b0;
      ack_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      sent_q      <= sent_d;
      ack_q       <= ack_d;
      seq_valid_q <= seq_valid_d;
      ack_valid_q <= ack_valid_d;
      fin_q       <= fin_d;
    end
  end

  assign stat_o.seq_ok     = (!seq_valid_q || lim <= cmd_i.seq) && (!ack_valid_q || ack_q != 32'd0);
  assign stat_o.changed    = changed;
  assign stat_o.state_next = state_d;

endmodule

### design/tcp_session_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_session_state_tracker
// follows one tcp session segment by segment, client and server state
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  in      | in_valid_i  | in_stall_o  | tcp_flags_i seq_number_i payload_length_i direction_i
//  out     | out_valid_o | out_stall_i | accepted_o toward_server_o data_available_o
//          |             |             | client_state_o server_state_o
//
//  one segment per cycle unless the result stalls; input register, then result register
//  the session state updates as a segment leaves the input register
//  rst_ni clears the session and both registers at once, no clearing pass
//  a stalled result holds the input register, which stalls the input channel
// ----------------------------------------------------------------------------
module tcp_session_state_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  tcp_flags_i,
  input  logic [31:0] seq_number_i,
  input  logic [15:0] payload_length_i,
  input  logic        direction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        toward_server_o,
  output logic        data_available_o,
  output logic [3:0]  client_state_o,
  output logic [3:0]  server_state_o
);

  logic        s_valid;
  logic [7:0]  s_flags;
  logic [31:0] s_seq;
  logic [15:0] s_len;
  logic        s_dir;
  logic        take;

  logic        dir_known_q, dir_known_d;
  logic        server_dir_q, server_dir_d;
  logic        acc;
  logic        snd_server;
  logic        tos;
  logic        avail;

  tst_pkg::ep_cmd_t  cli_cmd, srv_cmd;
  tst_pkg::ep_stat_t cli_stat, srv_stat;

  logic       out_valid_q, out_valid_d;
  logic       acc_q, tos_q, avail_q;
  logic [3:0] cli_q, srv_q;

  assign take = s_valid && (!out_valid_q || !out_stall_i);

  tst_in_stage u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .tcp_flags_i      (tcp_flags_i),
    .seq_number_i     (seq_number_i),
    .payload_length_i (payload_length_i),
    .direction_i      (direction_i),
    .take_i           (take),
    .valid_o          (s_valid),
    .flags_o          (s_flags),
    .seq_o            (s_seq),
    .len_o            (s_len),
    .dir_o            (s_dir)
  );

  always_comb begin
    dir_known_d  = dir_known_q;
    server_dir_d = server_dir_q;
    if (!dir_known_q) begin
      snd_server = 1'b0;
      acc        = (s_flags == tst_pkg::FlagSyn);
      tos        = 1'b1;
      if (take && acc) begin
        dir_known_d  = 1'b1;
        server_dir_d = s_dir;
      end
    end else begin
      snd_server = (s_dir != server_dir_q);
      acc        = snd_server ? srv_stat.seq_ok : cli_stat.seq_ok;
      tos        = !snd_server;
    end
  end

  always_comb begin
    cli_cmd.flags = s_flags;
    cli_cmd.seq   = s_seq;
    cli_cmd.len   = s_len;
    cli_cmd.send  = take && acc && !snd_server;
    cli_cmd.recv  = take && acc && snd_server;
    srv_cmd.flags = s_flags;
    srv_cmd.seq   = s_seq;
    srv_cmd.len   = s_len;
    srv_cmd.send  = take && acc && snd_server;
    srv_cmd.recv  = take && acc && !snd_server;
  end

  tst_endpoint u_client (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cli_cmd),
    .stat_o (cli_stat)
  );

  tst_endpoint u_server (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (srv_cmd),
    .stat_o (srv_stat)
  );

  assign avail = snd_server ?
                 (!srv_stat.changed && srv_stat.state_next == tst_pkg::StEstablished) :
                 (!cli_stat.changed && cli_stat.state_next == tst_pkg::StEstablished);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_known_q  <= 1'b0;
      server_dir_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      dir_known_q  <= dir_known_d;
      server_dir_q <= server_dir_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q   <= acc;
      tos_q   <= acc && tos;
      avail_q <= acc && avail;
      cli_q   <= cli_stat.state_next;
      srv_q   <= srv_stat.state_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign toward_server_o  = tos_q;
  assign data_available_o = avail_q;
  assign client_state_o   = cli_q;
  assign server_state_o   = srv_q;

  // rejected transactions report no direction and no data
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> !toward_server_o && !data_available_o)
    else $error("rejected result with direction or data flag");

  // data toward the server implies an established client
  a_avail_client: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_available_o && toward_server_o |->
      client_state_o == tst_pkg::StEstablished)
    else $error("data available without established client");

  // the server direction, once learned, is kept
  a_dir_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_known_q |=> dir_known_q && $stable(server_dir_q))
    else $error("server direction lost or changed");

  // before the first syn both endpoints stay closed
  a_closed_until_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dir_known_q && take |->
      (acc || (cli_stat.state_next == tst_pkg::StClosed &&
               srv_stat.state_next == tst_pkg::StClosed)))
    else $error("endpoint moved before direction known");

endmodule

### dv/tcp_session_state_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_session_state_tracker_tb
// drives one tcp session through the tracker and checks every result against
// a behavioral session predictor: handshake, data, flag noise and closing,
// with random gaps on both channels and a long result-side hold-off
// ----------------------------------------------------------------------------
module tcp_session_state_tracker_tb;

  localparam int EpClient = 0;
  localparam int EpServer = 1;

  typedef struct packed {
    logic       accepted;
    logic       toward_server;
    logic       data_available;
    logic [3:0] client_state;
    logic [3:0] server_state;
  } seg_result_t;

  class session_scoreboard;
    bit          dir_known;
    bit          server_dir;
    logic [3:0]  ep_state [2];
    logic [31:0] base_seq [2];
    logic [31:0] sent_len [2];
    logic [31:0] next_ack [2];
    bit          seq_valid [2];
    bit          ack_valid [2];
    bit          fin_pending [2];
    bit          changed [2];
    seg_result_t pending_results [$];
    int          mismatches;

    function new();
      dir_known  = 1'b0;
      server_dir = 1'b0;
      mismatches = 0;
      for (int e = 0; e < 2; e++) begin
        ep_state[e]    = tst_pkg::StClosed;
        base_seq[e]    = '0;
        sent_len[e]    = '0;
        next_ack[e]    = '0;
        seq_valid[e]   = 1'b0;
        ack_valid[e]   = 1'b0;
        fin_pending[e] = 1'b0;
        changed[e]     = 1'b0;
      end
    endfunction

    function void move_to(int e, logic [3:0] s);
      ep_state[e] = s;
      changed[e]  = 1'b1;
    endfunction

    function bit seq_passes(int e, logic [31:0] seq);
      logic [31:0] lim;
      lim = base_seq[e] + sent_len[e] + 32'd1;
      return (!seq_valid[e] || lim <= seq) && (!ack_valid[e] || next_ack[e] != 32'd0);
    endfunction

    // lowest sequence number the sender for this direction would pass with
    function logic [31:0] seq_floor(logic dir);
      int e;
      if (!dir_known) return '0;
      e = (dir == server_dir) ? EpClient : EpServer;
      return seq_valid[e] ? base_seq[e] + sent_len[e] + 32'd1 : '0;
    endfunction

    function void on_send(int e, logic [7:0] f, logic [31:0] seq, logic [15:0] len);
      changed[e] = 1'b0;
      case (ep_state[e])
        tst_pkg::StClosed: if (f == tst_pkg::FlagSyn) begin
          move_to(e, tst_pkg::StSynSent);
          base_seq[e]  = seq;
          seq_valid[e] = 1'b1;
        end
        tst_pkg::StListen: if (f == (tst_pkg::FlagSyn | tst_pkg::FlagAck)) begin
          move_to(e, tst_pkg::StSynRcvd);
          base_seq[e]  = seq;
          seq_valid[e] = 1'b1;
        end
        tst_pkg::StSynSent: if (f == tst_pkg::FlagAck) move_to(e, tst_pkg::StEstablished);
        tst_pkg::StSynRcvd: begin
          if (f == tst_pkg::FlagFin) move_to(e, tst_pkg::StFinWait1);
          else move_to(e, tst_pkg::StEstablished);
        end
        tst_pkg::StEstablished: begin
          if (f == tst_pkg::FlagFin) move_to(e, tst_pkg::StFinWait1);
          if (f == tst_pkg::FlagAck && fin_pending[e]) move_to(e, tst_pkg::StCloseWait);
        end
        tst_pkg::StFinWait1: if (f == tst_pkg::FlagAck) move_to(e, tst_pkg::StClosing);
        tst_pkg::StFinWait2: begin
          if (fin_pending[e] && f == tst_pkg::FlagAck) move_to(e, tst_pkg::StTimeWait);
        end
        tst_pkg::StCloseWait: if (f == tst_pkg::FlagFin) move_to(e, tst_pkg::StLastAck);
        tst_pkg::StLastAck: if (f == tst_pkg::FlagAck) move_to(e, tst_pkg::StClosed);
        default: ;
      endcase
      if (ep_state[e] == tst_pkg::StEstablished) sent_len[e] = sent_len[e] + {16'd0, len};
    endfunction

    function void on_recv(int e, logic [7:0] f, logic [31:0] seq, logic [15:0] len);
      changed[e] = 1'b0;
      case (ep_state[e])
        tst_pkg::StClosed: if (f == tst_pkg::FlagSyn) begin
          move_to(e, tst_pkg::StListen);
          next_ack[e]  = seq + 32'd1;
          ack_valid[e] = 1'b1;
        end
        tst_pkg::StSynSent: if (f == (tst_pkg::FlagSyn | tst_pkg::FlagAck)) begin
          next_ack[e]  = seq + 32'd1;
          ack_valid[e] = 1'b1;
        end
        tst_pkg::StEstablished, tst_pkg::StFinWait2: begin
          if (f == tst_pkg::FlagFin) fin_pending[e] = 1'b1;
        end
        tst_pkg::StFinWait1: if (f == tst_pkg::FlagAck) move_to(e, tst_pkg::StFinWait2);
        tst_pkg::StClosing: if (f == tst_pkg::FlagAck) move_to(e, tst_pkg::StTimeWait);
        default: ;
      endcase
      if (ep_state[e] == tst_pkg::StEstablished || ep_state[e] == tst_pkg::StSynRcvd) begin
        next_ack[e] = next_ack[e] + {16'd0, len};
      end
    endfunction

    function void note_segment(logic [7:0] flags, logic [31:0] seq, logic [15:0] len,
                               logic dir);
      logic [7:0]  f;
      int          snd;
      seg_result_t r;
      f = flags & tst_pkg::FlagMask;
      r = '0;
      if (!dir_known) begin
        if (f == tst_pkg::FlagSyn) begin
          dir_known  = 1'b1;
          server_dir = dir;
          on_send(EpClient, f, seq, len);
          on_recv(EpServer, f, seq, len);
          r.accepted = 1'b1;
        end
      end else begin
        snd = (dir == server_dir) ? EpClient : EpServer;
        if (seq_passes(snd, seq)) begin
          on_send(snd, f, seq, len);
          on_recv(1 - snd, f, seq, len);
          r.accepted = 1'b1;
        end
      end
      if (r.accepted) begin
        snd = (dir == server_dir) ? EpClient : EpServer;
        r.toward_server  = (dir == server_dir);
        r.data_available = !changed[snd] && ep_state[snd] == tst_pkg::StEstablished;
      end
      r.client_state = ep_state[EpClient];
      r.server_state = ep_state[EpServer];
      pending_results.push_back(r);
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected transaction acc=%0d tos=%0d avail=%0d client=%0d server=%0d",
                   $realtime, got.accepted, got.toward_server, got.data_available,
                   got.client_state, got.server_state);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected acc=%0d tos=%0d avail=%0d client=%0d server=%0d",
                   $realtime, want.accepted, want.toward_server, want.data_available,
                   want.client_state, want.server_state);
          $display("%0t:          actual   acc=%0d tos=%0d avail=%0d client=%0d server=%0d",
                   $realtime, got.accepted, got.toward_server, got.data_available,
                   got.client_state, got.server_state);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  tcp_flags_i;
  logic [31:0] seq_number_i;
  logic [15:0] payload_length_i;
  logic        direction_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        accepted_o;
  logic        toward_server_o;
  logic        data_available_o;
  logic [3:0]  client_state_o;
  logic [3:0]  server_state_o;

  session_scoreboard sb;
  int send_idle_pct = 36;
  int recv_idle_pct = 70;
  bit hold_request  = 1'b0;
  int hold_left     = 0;

  tcp_session_state_tracker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .tcp_flags_i      (tcp_flags_i),
    .seq_number_i     (seq_number_i),
    .payload_length_i (payload_length_i),
    .direction_i      (direction_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .toward_server_o  (toward_server_o),
    .data_available_o (data_available_o),
    .client_state_o   (client_state_o),
    .server_state_o   (server_state_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = 80;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({accepted_o, toward_server_o, data_available_o,
                       client_state_o, server_state_o});
    end
  end

  task automatic send_segment(logic [7:0] flags, logic [31:0] seq, logic [15:0] len,
                              logic dir);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    tcp_flags_i      <= flags;
    seq_number_i     <= seq;
    payload_length_i <= len;
    direction_i      <= dir;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_segment(flags, seq, len, dir);
  endtask

  task automatic send_random_segment();
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [15:0] len;
    logic        dir;
    int          pick;
    dir  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 55)      flags = tst_pkg::FlagAck;
    else if (pick < 58) flags = tst_pkg::FlagFin;
    else if (pick < 63) flags = tst_pkg::FlagSyn;
    else if (pick < 68) flags = tst_pkg::FlagSyn | tst_pkg::FlagAck;
    else if (pick < 74) flags = tst_pkg::FlagRst;
    else if (pick < 79) flags = tst_pkg::FlagFin | tst_pkg::FlagAck;
    else if (pick < 84) flags = 8'h00;
    else                flags = 8'($urandom_range(0, 255));
    // psh, urg, ece and cwr noise on top
    if ($urandom_range(0, 3) == 0) begin
      flags = flags | (8'($urandom_range(0, 255)) & ~tst_pkg::FlagMask);
    end
    pick = $urandom_range(0, 99);
    if (pick < 75)      seq = sb.seq_floor(dir) + 32'($urandom_range(0, 2000));
    else if (pick < 85) seq = sb.seq_floor(dir) - 32'd1;
    else                seq = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60)      len = 16'($urandom_range(0, 1460));
    else if (pick < 70) len = 16'd0;
    else if (pick < 80) len = 16'hffff;
    else                len = 16'($urandom_range(0, 65535));
    send_segment(flags, seq, len, dir);
  endtask

  task automatic drain_results();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    tcp_flags_i      = '0;
    seq_number_i     = '0;
    payload_length_i = '0;
    direction_i      = 1'b0;
    out_stall_i      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // no server direction yet: only a bare syn gets in
    send_segment(tst_pkg::FlagAck, 32'd0, 16'd0, 1'b0);
    send_segment(8'hff, 32'hffffffff, 16'hffff, 1'b0);
    // syn hidden among psh, urg, ece and cwr; client sends right-to-left
    send_segment(8'hea, 32'd100, 16'hffff, 1'b1);
    send_segment(tst_pkg::FlagSyn, 32'd100, 16'd0, 1'b1);
    // syn-ack at the top of the range leaves the client a zero next-ack
    send_segment(tst_pkg::FlagSyn | tst_pkg::FlagAck, 32'hffffffff, 16'h1234, 1'b0);
    send_segment(tst_pkg::FlagAck, 32'd1000, 16'd1, 1'b1);
    send_segment(tst_pkg::FlagSyn | tst_pkg::FlagAck, 32'd5, 16'd0, 1'b0);
    send_segment(tst_pkg::FlagAck, 32'd101, 16'd10, 1'b1);
    send_segment(8'h18, 32'hffffffff, 16'hffff, 1'b1);
    send_segment(tst_pkg::FlagAck, 32'd0, 16'd4, 1'b1);
    send_segment(tst_pkg::FlagRst, 32'd0, 16'd7, 1'b0);
    send_segment(tst_pkg::FlagFin | tst_pkg::FlagAck, 32'd100, 16'd0, 1'b0);
    send_segment(8'h00, 32'd200, 16'd3, 1'b0);
    send_segment(tst_pkg::FlagSyn | tst_pkg::FlagAck, 32'h7fffffff, 16'h8000, 1'b1);
    send_segment(tst_pkg::FlagAck, 32'h80000000, 16'h5555, 1'b0);
    send_segment(tst_pkg::FlagAck, 32'haaaaaaaa, 16'haaaa, 1'b1);
    drain_results();

    for (int i = 0; i < 200; i++) send_random_segment();
    drain_results();

    send_idle_pct = 70;
    recv_idle_pct = 36;
    for (int i = 0; i < 200; i++) send_random_segment();
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i) hold_request = 1'b1;
    for (int i = 0; i < 200; i++) send_random_segment();
    drain_results();
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
